>>> rtl/core/svsd_pkg.sv
// Shared types and constants for the strided view slice descriptor.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package svsd_pkg;

    localparam int DIM_BITS_DEF = 32;
    localparam int FIELD_W      = 32;
    localparam int OFFSET_W     = 48;
    localparam int STEP_W       = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic norm;
        logic mul;
        logic div_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage

>>> rtl/core/svsd_ctrl.sv
// Sequencer for one dimension: normalize, multiply, divide, emit.
// Depends on svsd_pkg for the state, command and status types.
`timescale 1ns / 1ps

module svsd_ctrl
    import svsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd,
    output state_t  state
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:  state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_NORM:  cmd.norm = 1'b1;
            S_MUL:   cmd.mul = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_OUT:   cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

    assign state = state_reg;

endmodule

>>> rtl/core/svsd_dpath.sv
// Datapath: input capture, slice clamping, multipliers, radix-2 divider,
// running offset and output register. Depends on svsd_pkg.
`timescale 1ns / 1ps

module svsd_dpath
    import svsd_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                cfg_valid,
    input  logic [OFFSET_W-1:0] cfg_data,
    input  logic [FIELD_W-1:0]  base_size,
    input  logic [FIELD_W-1:0]  base_stride,
    input  logic [FIELD_W-1:0]  slice_start,
    input  logic [FIELD_W-1:0]  slice_end,
    input  logic [STEP_W-1:0]   slice_step,
    input  logic                last_dim,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FIELD_W-1:0]  view_size,
    output logic [OFFSET_W-1:0] view_stride,
    output logic [FIELD_W-1:0]  view_start,
    output logic [OFFSET_W-1:0] view_offset,
    output logic                bad_step,
    output logic                view_last
);

    localparam int CNT_W  = $clog2(DIM_BITS);
    localparam int PROD_W = DIM_BITS + FIELD_W;
    localparam int SW     = FIELD_W + 2;

    // captured beat
    logic [DIM_BITS-1:0] size_reg;
    logic [FIELD_W-1:0]  stride_reg;
    logic [FIELD_W-1:0]  s_reg;
    logic [FIELD_W-1:0]  e_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                last_reg;

    // normalized slice
    logic [DIM_BITS-1:0] start_reg;
    logic [DIM_BITS-1:0] diffm1_reg;
    logic                nonempty_reg;
    logic [OFFSET_W-1:0] vstride_reg;
    logic [OFFSET_W-1:0] sprod_reg;

    // divider
    logic [DIM_BITS-1:0] quo_reg;
    logic [STEP_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // control state
    logic [OFFSET_W-1:0] base_offset_reg;
    logic [OFFSET_W-1:0] acc_reg;
    logic [OFFSET_W-1:0] acc_next;
    logic                mid_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    // output register
    logic [FIELD_W-1:0]  view_size_reg;
    logic [OFFSET_W-1:0] view_stride_reg;
    logic [FIELD_W-1:0]  view_start_reg;
    logic [OFFSET_W-1:0] view_offset_reg;
    logic                bad_step_reg;
    logic                view_last_reg;

    logic signed [SW-1:0] size_s;
    logic signed [SW-1:0] s_adj;
    logic signed [SW-1:0] e_adj;
    logic signed [SW-1:0] start_c;
    logic signed [SW-1:0] end_c;
    logic signed [SW-1:0] diffm1_s;
    logic [PROD_W-1:0]    sprod;
    logic [STEP_W:0]      rem_sh;
    logic [STEP_W:0]      rem_sub;
    logic                 q_bit;
    logic [DIM_BITS-1:0]  q_inc;

    // wrap negative starts and non-positive ends, then clamp both to 0..size
    always_comb
    begin
        size_s = SW'(size_reg);
        s_adj  = {{2{s_reg[FIELD_W-1]}}, s_reg};
        e_adj  = {{2{e_reg[FIELD_W-1]}}, e_reg};
        if (s_adj < 0)
        begin
            s_adj = s_adj + size_s;
        end
        if (e_adj <= 0)
        begin
            e_adj = e_adj + size_s;
        end
        priority if (s_adj < 0)
            start_c = '0;
        else if (s_adj > size_s)
            start_c = size_s;
        else
            start_c = s_adj;
        priority if (e_adj < 0)
            end_c = '0;
        else if (e_adj > size_s)
            end_c = size_s;
        else
            end_c = e_adj;
        diffm1_s = end_c - start_c - SW'(1);
    end

    assign sprod = PROD_W'(start_reg) * PROD_W'(stride_reg);

    // one restoring step: bring in the next dividend bit
    assign rem_sh  = {rem_reg, quo_reg[DIM_BITS-1]};
    assign rem_sub = rem_sh - (STEP_W + 1)'(step_reg);
    assign q_bit   = (rem_sh >= (STEP_W + 1)'(step_reg));

    // ceil(diff / step) = floor((diff - 1) / step) + 1
    assign q_inc = quo_reg + DIM_BITS'(1);

    assign acc_next = (mid_reg ? acc_reg : base_offset_reg) + sprod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            size_reg   <= DIM_BITS'(base_size);
            stride_reg <= base_stride;
            s_reg      <= slice_start;
            e_reg      <= slice_end;
            step_reg   <= slice_step;
            last_reg   <= last_dim;
        end
        if (cmd.norm)
        begin
            start_reg    <= start_c[DIM_BITS-1:0];
            diffm1_reg   <= diffm1_s[DIM_BITS-1:0];
            nonempty_reg <= (end_c > start_c);
            vstride_reg  <= OFFSET_W'(stride_reg) * OFFSET_W'(step_reg);
        end
        if (cmd.mul)
        begin
            sprod_reg <= OFFSET_W'(sprod);
            quo_reg   <= diffm1_reg;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DIM_BITS-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.load_out)
        begin
            view_size_reg   <= (nonempty_reg && (step_reg != '0)) ? FIELD_W'(q_inc) : '0;
            view_stride_reg <= vstride_reg;
            view_start_reg  <= FIELD_W'(start_reg);
            view_offset_reg <= acc_next;
            bad_step_reg    <= (step_reg == '0);
            view_last_reg   <= last_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= '0;
            acc_reg         <= '0;
            mid_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_offset_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                acc_reg <= acc_next;
                mid_reg <= !last_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.div_last = (cnt_reg == CNT_W'(DIM_BITS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign view_size   = view_size_reg;
    assign view_stride = view_stride_reg;
    assign view_start  = view_start_reg;
    assign view_offset = view_offset_reg;
    assign bad_step    = bad_step_reg;
    assign view_last   = view_last_reg;

endmodule

>>> rtl/core/strided_view_slice_descriptor.sv
// Top level of the strided view slice descriptor: controller plus datapath.
// Depends on svsd_pkg, svsd_ctrl and svsd_dpath.
//
//   channel   direction  handshake              beat contents
//   cfg       in         cfg_valid/cfg_ready    cfg_data = base_offset
//   in        in         in_valid/in_ready      one base dimension and slice
//   out       out        out_valid/out_ready    one view dimension
//
// An item is accepted only in idle; the next item is not taken until the current one has gone
// through normalize, multiply, the radix-2 divider for the ceiling division and emit.
// rst_n clears the base offset, running offset, view position and valid flags.
// A stalled output holds the controller before it returns to idle; a result
// already in the output register does not stop the next item from starting.
`timescale 1ns / 1ps

module strided_view_slice_descriptor
    import svsd_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [OFFSET_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FIELD_W-1:0]  base_size,
    input  logic [FIELD_W-1:0]  base_stride,
    input  logic [FIELD_W-1:0]  slice_start,
    input  logic [FIELD_W-1:0]  slice_end,
    input  logic [STEP_W-1:0]   slice_step,
    input  logic                last_dim,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FIELD_W-1:0]  view_size,
    output logic [OFFSET_W-1:0] view_stride,
    output logic [FIELD_W-1:0]  view_start,
    output logic [OFFSET_W-1:0] view_offset,
    output logic                bad_step,
    output logic                view_last
);

    cmd_t    cmd;
    status_t status;
    state_t  state;

    assign cfg_ready = 1'b1;

    svsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    svsd_dpath #(
        .DIM_BITS (DIM_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .base_size   (base_size),
        .base_stride (base_stride),
        .slice_start (slice_start),
        .slice_end   (slice_end),
        .slice_step  (slice_step),
        .last_dim    (last_dim),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .view_size   (view_size),
        .view_stride (view_stride),
        .view_start  (view_start),
        .view_offset (view_offset),
        .bad_step    (bad_step),
        .view_last   (view_last)
    );

`ifndef SYNTHESIS
    // an accepted beat keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again right after an accept");

    // a zero step never yields a nonzero size or stride
    a_bad_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_step |-> (view_size == '0) && (view_stride == '0))
        else $error("zero step produced nonzero size or stride");

    // a result is loaded only from the emit state
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (state == S_OUT) && (!out_valid || out_ready))
        else $error("result loaded outside the emit state or over a pending beat");

    // the divider leaves only after its last step
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state == S_DIV) && !status.div_last |=> (state == S_DIV))
        else $error("divider left early");
`endif

endmodule

>>> sim/tb.sv
// Self-checking bench for strided_view_slice_descriptor: directed and random slice dims
// go through a queued driver, and every view beat is checked against an in-bench predictor.
// Depends on svsd_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
    import svsd_pkg::*;

    localparam int DIM_W        = DIM_BITS_DEF;
    localparam int VIEW_RANK    = 8;
    localparam int DRAIN_CYCLES = DIM_W + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    typedef logic [63:0] u64_t;

    typedef struct {
        logic [FIELD_W-1:0] base_size;
        logic [FIELD_W-1:0] base_stride;
        logic [FIELD_W-1:0] slice_start;
        logic [FIELD_W-1:0] slice_end;
        logic [STEP_W-1:0]  slice_step;
        logic               last_dim;
    } slice_dim_t;

    typedef struct {
        logic [FIELD_W-1:0]  view_size;
        logic [OFFSET_W-1:0] view_stride;
        logic [FIELD_W-1:0]  view_start;
        logic [OFFSET_W-1:0] view_offset;
        logic                bad_step;
        logic                view_last;
    } view_dim_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [OFFSET_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [FIELD_W-1:0]  view_size;
    logic [OFFSET_W-1:0] view_stride;
    logic [FIELD_W-1:0]  view_start;
    logic [OFFSET_W-1:0] view_offset;
    logic                bad_step;
    logic                view_last;

    slice_dim_t cur_dim = '{default: '0};
    slice_dim_t pending_dims[$];
    view_dim_t  views_due[$];

    // predictor state and its copy of the register
    logic [OFFSET_W-1:0] base_offset_cfg = '0;
    logic [OFFSET_W-1:0] offset_run      = '0;
    logic                in_view         = 1'b0;

    logic in_acc        = 1'b0;
    bit   idle_on       = 1'b1;
    bit   hold_request  = 1'b0;
    int   send_gap      = 0;
    int   stall_left    = 0;
    int   hold_left     = 0;
    int   cycle_count   = 0;
    int   mismatch_count = 0;

    always #5 clk = ~clk;

    strided_view_slice_descriptor #(.DIM_BITS(DIM_W)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .base_size   (cur_dim.base_size),
        .base_stride (cur_dim.base_stride),
        .slice_start (cur_dim.slice_start),
        .slice_end   (cur_dim.slice_end),
        .slice_step  (cur_dim.slice_step),
        .last_dim    (cur_dim.last_dim),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .view_size   (view_size),
        .view_stride (view_stride),
        .view_start  (view_start),
        .view_offset (view_offset),
        .bad_step    (bad_step),
        .view_last   (view_last)
    );

    // Normalize one slice dim and advance the running view offset.
    function automatic view_dim_t predict_view_dim(input slice_dim_t d);
        longint    ext;
        longint    first;
        longint    stop;
        longint    span;
        view_dim_t r;
        ext   = longint'(d.base_size) & ((longint'(1) << DIM_W) - 1);
        first = longint'(signed'(d.slice_start));
        stop  = longint'(signed'(d.slice_end));
        if (stop <= 0)
            stop += ext;
        if (first < 0)
            first += ext;
        if (stop < 0)
            stop = 0;
        else if (stop > ext)
            stop = ext;
        if (first < 0)
            first = 0;
        else if (first > ext)
            first = ext;
        r.view_size = '0;
        if (d.slice_step != 0 && stop > first)
        begin
            span = stop - first;
            r.view_size = FIELD_W'((span + longint'(d.slice_step) - 1) / longint'(d.slice_step));
        end
        r.view_stride = OFFSET_W'(u64_t'(d.base_stride) * u64_t'(d.slice_step));
        r.view_start  = FIELD_W'(first);
        // first dim of a view restarts from the base offset
        if (!in_view)
            offset_run = base_offset_cfg;
        offset_run = OFFSET_W'(u64_t'(offset_run) + u64_t'(first) * u64_t'(d.base_stride));
        in_view = !d.last_dim;
        r.view_offset = offset_run;
        r.bad_step    = (d.slice_step == 0);
        r.view_last   = d.last_dim;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input u64_t got, input u64_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Monitor: check view beats, predict on each accepted slice beat, watch the limit.
    always @(posedge clk)
    begin
        view_dim_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (views_due.size() == 0)
                begin
                    report_mismatch("view beat with nothing expected");
                end
                else
                begin
                    want = views_due.pop_front();
                    check_field("view_size", view_size, want.view_size);
                    check_field("view_stride", view_stride, want.view_stride);
                    check_field("view_start", view_start, want.view_start);
                    check_field("view_offset", view_offset, want.view_offset);
                    check_field("bad_step", bad_step, want.bad_step);
                    check_field("view_last", view_last, want.view_last);
                end
            end
            if (in_valid && in_ready)
                views_due = {views_due, predict_view_dim(cur_dim)};
            in_acc <= in_valid && in_ready;
        end
    end

    // Driver: hold the beat until taken, then idle or send the next one.
    always @(negedge clk)
    begin
        logic       offer;
        slice_dim_t nxt;
        offer = in_valid;
        nxt   = cur_dim;
        if (!rst_n)
        begin
            offer = 1'b0;
        end
        else if (!in_valid || in_acc)
        begin
            offer = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_dims.size() > 0)
            begin
                nxt   = pending_dims.pop_front();
                offer = 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end
        end
        in_valid <= offer;
        cur_dim  <= nxt;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge clk)
    begin
        logic take;
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        take = 1'b1;
        if (hold_left > 0)
        begin
            hold_left--;
            take = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            take = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 19);
        end
        out_ready <= take;
    end

    function automatic logic [FIELD_W-1:0] random_index(input logic [FIELD_W-1:0] ext);
        logic [FIELD_W-1:0] mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                mag = $urandom_range(0, (ext > 32'hFFFF_FF00) ? 32'hFFFF_FFFF : ext + 4);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            5:       return $urandom;
            6:       return 32'h8000_0000;
            7:       return '0;
            8:       return '1;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic slice_dim_t random_dim();
        slice_dim_t d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: d.base_size = $urandom_range(0, 64);
            6:                d.base_size = $urandom_range(0, 4096);
            7:                d.base_size = $urandom;
            8:                d.base_size = '0;
            default:          d.base_size = '1;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: d.base_stride = $urandom_range(0, 256);
            6, 7, 8:          d.base_stride = $urandom;
            default:          d.base_stride = '1;
        endcase
        d.slice_start = random_index(d.base_size);
        d.slice_end   = random_index(d.base_size);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: d.slice_step = $urandom_range(1, 8);
            6:                d.slice_step = $urandom_range(1, 65535);
            7:                d.slice_step = '0;
            8:                d.slice_step = '1;
            default:          d.slice_step = 16'd1;
        endcase
        d.last_dim = 1'b0;
        return d;
    endfunction

    // Queue whole views; about one in ten gets random last marks.
    task automatic queue_views(input int target);
        int         added;
        int         rank;
        bit         noisy;
        slice_dim_t d;
        added = 0;
        while (added < target)
        begin
            rank  = ($urandom_range(0, 9) == 0) ? $urandom_range(VIEW_RANK + 1, VIEW_RANK + 4)
                                                : $urandom_range(1, VIEW_RANK);
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < rank; k++)
            begin
                d = random_dim();
                d.last_dim = noisy ? 1'($urandom_range(0, 1)) : (k == rank - 1);
                pending_dims = {pending_dims, d};
            end
            added += rank;
        end
    endtask

    task automatic add_dim(input logic [FIELD_W-1:0] ext, input logic [FIELD_W-1:0] stride,
                           input logic [FIELD_W-1:0] first, input logic [FIELD_W-1:0] stop,
                           input logic [STEP_W-1:0] step, input logic is_last);
        slice_dim_t d;
        d.base_size   = ext;
        d.base_stride = stride;
        d.slice_start = first;
        d.slice_end   = stop;
        d.slice_step  = step;
        d.last_dim    = is_last;
        pending_dims = {pending_dims, d};
    endtask

    task automatic write_base_offset(input logic [OFFSET_W-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        base_offset_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pause the sender until every view beat is back and the block has settled.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_dims.size() != 0 || in_valid || views_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed dims, offset wraps from the top of the range
        write_base_offset(OFFSET_MAX);
        add_dim(0, 0, 0, 0, 1, 1);                                  // zero extent
        add_dim('1, '1, 32'h7FFF_FFFF, 32'h8000_0000, '1, 1);
        add_dim(100, 3, 32'h8000_0000, 0, 1, 1);                   // end zero means full
        add_dim(100, 3, -10, -1, 1, 1);                            // both from the end
        add_dim(100, 7, 5, 50, 0, 1);                              // zero step
        add_dim(100, 7, 60, 20, 2, 1);                             // reversed
        add_dim(100, 7, 20, 20, 1, 1);                             // empty
        add_dim(10, 1, 1, 10, 4, 1);                               // rounds up
        add_dim(10, 1, 0, 10, 5, 1);                               // exact division
        add_dim(10, 1, 15, 30, 1, 1);                              // start past extent
        add_dim(10, 1, -30, 5, 1, 1);                              // start below zero
        add_dim(10, 1, 2, -30, 1, 1);                              // end below zero
        add_dim('1, '1, 32'h7FFF_FFFF, 0, 1, 0);                   // three-dim view
        add_dim('1, '1, -1, 0, 2, 0);
        add_dim(1000, 32'h1234_5678, 999, 1000, 1, 1);
        add_dim(5, 2, 0, 32'h7FFF_FFFF, 1, 0);
        add_dim(5, 2, 4, 5, 1, 0);
        add_dim(5, 2, -5, -2, 3, 1);
        add_dim(20, 4, 0, 20, '1, 1);                              // step beyond span
        add_dim(1, 0, 0, 1, 1, 1);
        wait_drained();

        // receiver holds off while the sender keeps offering
        write_base_offset('0);
        queue_views(280);
        hold_request = 1'b1;
        wait_drained();

        write_base_offset(OFFSET_W'({$urandom, $urandom}));
        queue_views(280);
        wait_drained();

        // last stretch at full rate
        write_base_offset(OFFSET_W'({$urandom, $urandom}));
        idle_on = 1'b0;
        queue_views(270);
        wait_drained();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> strided_view_slice_descriptor.f
rtl/core/svsd_pkg.sv
rtl/core/svsd_ctrl.sv
rtl/core/svsd_dpath.sv
rtl/core/strided_view_slice_descriptor.sv
sim/tb.sv
